/* rtl/core/assert_macros.svh */
// Assertion macros shared by the sequencer RTL.
// Assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("sequencer assertion failed");
`define SPS_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
	else $error("sequencer forbidden condition");
`else
`define SPS_ASSERT(lbl, clk, rstn, prop)
`define SPS_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* rtl/core/sps_pkg.sv */
// Types, codes and constants of the stepper position sequencer.
// No dependencies.
`timescale 1ns / 1ps
package sps_pkg;

	localparam int TARGET_BITS = 12;
	localparam int SCALE_W     = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int NUM_MOTORS  = 3;
	localparam int ROUND_HALF  = 128;

	localparam logic FUNC_CMD  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic [1:0] MOTOR_ACCEL   = 2'd0;
	localparam logic [1:0] MOTOR_DEFLECT = 2'd1;
	localparam logic [1:0] MOTOR_MAGNET  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFLECT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGNET  = 2'd3;

	localparam logic [CFG_W-1:0] HOLD_RESET  = 16'd1000;
	localparam logic [CFG_W-1:0] SCALE_RESET = 16'd256;

	typedef struct packed {
		logic                   func;
		logic [1:0]             motor_id;
		logic [TARGET_BITS-1:0] target_level;
	} cmd_t;

	typedef struct packed {
		logic [3:0] accel_coils;
		logic [3:0] deflect_coils;
		logic [3:0] magnet_coils;
		logic       busy_res;
		logic       accepted;
		logic       move_done;
	} res_t;

	function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
		logic [3:0] pat;
		case (phase)
			2'd0: pat = 4'h3;
			2'd1: pat = 4'h6;
			2'd2: pat = 4'hC;
			2'd3: pat = 4'h9;
			default: pat = 4'h3;
		endcase
		return pat;
	endfunction

	function automatic logic [1:0] next_phase(input logic [1:0] phase, input logic backward);
		return backward ? phase - 2'd1 : phase + 2'd1;
	endfunction

endpackage

/* rtl/core/sps_step_count.sv */
// Step count of a move: round(diff * scale) for a Q8.8 scale, saturated.
// Depends on sps_pkg.
`timescale 1ns / 1ps
module sps_step_count #(
	parameter int STEP_COUNT_BITS = 24
) (
	input  logic [sps_pkg::TARGET_BITS-1:0] diff,
	input  logic [sps_pkg::SCALE_W-1:0]     scale,
	output logic [STEP_COUNT_BITS-1:0]      count
);

	localparam int PROD_W = sps_pkg::TARGET_BITS + sps_pkg::SCALE_W;
	localparam int RND_W  = PROD_W - 7;
	localparam int WIDE_W = (RND_W > STEP_COUNT_BITS) ? RND_W : STEP_COUNT_BITS;
	localparam logic [WIDE_W-1:0] CMAX = WIDE_W'({STEP_COUNT_BITS{1'b1}});

	logic [PROD_W-1:0] prod;
	logic [PROD_W:0]   sum;
	logic [WIDE_W-1:0] rnd_w;

	assign prod  = PROD_W'(diff) * PROD_W'(scale);
	assign sum   = {1'b0, prod} + (PROD_W + 1)'(sps_pkg::ROUND_HALF);
	assign rnd_w = WIDE_W'(sum[PROD_W:8]);
	assign count = (rnd_w > CMAX) ? CMAX[STEP_COUNT_BITS-1:0] : rnd_w[STEP_COUNT_BITS-1:0];

endmodule

/* rtl/core/stepper_position_sequencer_core.sv */
// Throughput: one transaction per cycle while res_stall does not hold a result;
// each transaction yields one result.
// An input register feeds one pass of update logic into the result register.
// Reset (arst_n low, asynchronous) clears positions, phases and counters, idles
// the motors and loads hold 1000 and all scales 256.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stepper_position_sequencer_core #(
	parameter int STEP_COUNT_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cmd_valid,
	output logic                             cmd_stall,
	input  sps_pkg::cmd_t                    cmd,
	output logic                             res_valid,
	input  logic                             res_stall,
	output sps_pkg::res_t                    res,
	input  logic                             cfg_we,
	input  logic [sps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sps_pkg::CFG_W-1:0]        cfg_data
);

	localparam int TB = sps_pkg::TARGET_BITS;

	logic [sps_pkg::CFG_W-1:0] hold_cfg_q, accel_cfg_q, deflect_cfg_q, magnet_cfg_q;

	logic          valid_s1;
	sps_pkg::cmd_t cmd_s1;
	logic          fire;

	logic [TB-1:0]               pos_q   [sps_pkg::NUM_MOTORS];
	logic [1:0]                  phase_q [sps_pkg::NUM_MOTORS];
	logic [STEP_COUNT_BITS-1:0]  steps_q;
	logic [sps_pkg::CFG_W-1:0]   hold_q;
	logic [1:0]                  active_q;
	logic                        backward_q;
	logic                        moving_q;

	logic [TB-1:0]               pos_n   [sps_pkg::NUM_MOTORS];
	logic [1:0]                  phase_n [sps_pkg::NUM_MOTORS];
	logic [STEP_COUNT_BITS-1:0]  steps_n;
	logic [sps_pkg::CFG_W-1:0]   hold_n;
	logic [1:0]                  active_n;
	logic                        backward_n;
	logic                        moving_n;

	logic [3:0]                  coils [sps_pkg::NUM_MOTORS];
	logic                        acc, done;
	logic                        id_ok;
	logic [TB-1:0]               cur_pos;
	logic [TB-1:0]               diff;
	logic [sps_pkg::SCALE_W-1:0] scale;
	logic [STEP_COUNT_BITS-1:0]  cnt;
	logic [sps_pkg::CFG_W-1:0]   hold_val;
	logic [sps_pkg::CFG_W-1:0]   hold_dec;
	logic [STEP_COUNT_BITS-1:0]  steps_dec;
	logic                        back_new;

	sps_pkg::res_t res_n;
	sps_pkg::res_t res_q;
	logic          res_valid_q;
	logic          advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cfg_q    <= sps_pkg::HOLD_RESET;
			accel_cfg_q   <= sps_pkg::SCALE_RESET;
			deflect_cfg_q <= sps_pkg::SCALE_RESET;
			magnet_cfg_q  <= sps_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				sps_pkg::CFG_HOLD:    hold_cfg_q    <= cfg_data;
				sps_pkg::CFG_ACCEL:   accel_cfg_q   <= cfg_data;
				sps_pkg::CFG_DEFLECT: deflect_cfg_q <= cfg_data;
				sps_pkg::CFG_MAGNET:  magnet_cfg_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake
	assign advance   = !res_valid_q || !res_stall;
	assign cmd_stall = valid_s1 && !advance;
	assign fire      = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	// operand selection
	always_comb begin
		id_ok   = 1'b1;
		cur_pos = pos_q[0];
		scale   = accel_cfg_q;
		case (cmd_s1.motor_id)
			sps_pkg::MOTOR_ACCEL: begin
				cur_pos = pos_q[0];
				scale   = accel_cfg_q;
			end
			sps_pkg::MOTOR_DEFLECT: begin
				cur_pos = pos_q[1];
				scale   = deflect_cfg_q;
			end
			sps_pkg::MOTOR_MAGNET: begin
				cur_pos = pos_q[2];
				scale   = magnet_cfg_q;
			end
			default: id_ok = 1'b0;
		endcase
	end

	assign back_new = cmd_s1.target_level < cur_pos;
	assign diff     = back_new ? cur_pos - cmd_s1.target_level : cmd_s1.target_level - cur_pos;
	assign hold_val = (hold_cfg_q == '0) ? sps_pkg::CFG_W'(1) : hold_cfg_q;
	assign hold_dec = (hold_q != '0) ? hold_q - sps_pkg::CFG_W'(1) : '0;
	assign steps_dec = (steps_q != '0) ? steps_q - STEP_COUNT_BITS'(1) : '0;

	sps_step_count #(
		.STEP_COUNT_BITS(STEP_COUNT_BITS)
	) u_step_count (
		.diff  (diff),
		.scale (scale),
		.count (cnt)
	);

	// item update
	always_comb begin
		pos_n      = pos_q;
		phase_n    = phase_q;
		steps_n    = steps_q;
		hold_n     = hold_q;
		active_n   = active_q;
		backward_n = backward_q;
		moving_n   = moving_q;
		coils      = '{default: 4'h0};
		acc        = 1'b0;
		done       = 1'b0;
		if (cmd_s1.func == sps_pkg::FUNC_CMD) begin
			if (!moving_q && id_ok) begin
				acc = 1'b1;
				pos_n[cmd_s1.motor_id] = cmd_s1.target_level;
				if (cnt != '0) begin
					backward_n = back_new;
					active_n   = cmd_s1.motor_id;
					steps_n    = cnt;
					hold_n     = hold_val;
					moving_n   = 1'b1;
					phase_n[cmd_s1.motor_id] =
						sps_pkg::next_phase(phase_q[cmd_s1.motor_id], back_new);
				end
			end
		end else if (moving_q) begin
			coils[active_q] = sps_pkg::coil_pattern(phase_q[active_q]);
			hold_n = hold_dec;
			if (hold_dec == '0) begin
				steps_n = steps_dec;
				if (steps_dec == '0) begin
					moving_n = 1'b0;
					done     = 1'b1;
				end else begin
					phase_n[active_q] = sps_pkg::next_phase(phase_q[active_q], backward_q);
					hold_n = hold_val;
				end
			end
		end
		res_n.accel_coils   = coils[0];
		res_n.deflect_coils = coils[1];
		res_n.magnet_coils  = coils[2];
		res_n.busy_res      = moving_n;
		res_n.accepted      = acc;
		res_n.move_done     = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '{default: '0};
			phase_q    <= '{default: 2'd0};
			steps_q    <= '0;
			hold_q     <= '0;
			active_q   <= sps_pkg::MOTOR_ACCEL;
			backward_q <= 1'b0;
			moving_q   <= 1'b0;
		end else if (fire) begin
			pos_q      <= pos_n;
			phase_q    <= phase_n;
			steps_q    <= steps_n;
			hold_q     <= hold_n;
			active_q   <= active_n;
			backward_q <= backward_n;
			moving_q   <= moving_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`SPS_ASSERT(a_moving_has_steps, clk, arst_n, moving_q |-> (steps_q != '0 && hold_q != '0))
	`SPS_ASSERT(a_active_in_range, clk, arst_n, moving_q |-> (active_q != 2'd3))
	`SPS_ASSERT(a_one_motor_driven, clk, arst_n,
		res_valid_q |-> $onehot0({|res_q.accel_coils, |res_q.deflect_coils, |res_q.magnet_coils}))
	`SPS_ASSERT(a_accept_quiet, clk, arst_n,
		(res_valid_q && res_q.accepted) |-> (!res_q.move_done && res_q.accel_coils == 4'h0 &&
		res_q.deflect_coils == 4'h0 && res_q.magnet_coils == 4'h0))
	`SPS_ASSERT(a_done_ends_move, clk, arst_n, (fire && done) |=> !moving_q)

endmodule
